FILE: src/mkpd_pkg.sv
// shared types, constants and key table for the keypad press decoder
package mkpd_pkg;

   localparam int BUFFER_SIZE = 32;
   localparam int CNT_W       = $clog2(BUFFER_SIZE + 1);
   localparam int ADDR_W      = $clog2(BUFFER_SIZE);

   localparam logic [1:0] FUNC_SCAN  = 2'd0;
   localparam logic [1:0] FUNC_FLUSH = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   typedef logic [6:0] char_type;

   localparam char_type SPACE_CHAR = 7'd32;

   typedef struct packed {
      logic     seen;
      char_type key;
   } scan_result_type;

   function automatic char_type key_lookup(input logic [1:0] row, input logic [1:0] col);
      char_type ch;
      unique case ({row, col})
         4'h0: ch = 7'h31;  // '1'
         4'h1: ch = 7'h32;  // '2'
         4'h2: ch = 7'h33;  // '3'
         4'h3: ch = 7'h41;  // 'A'
         4'h4: ch = 7'h34;  // '4'
         4'h5: ch = 7'h35;  // '5'
         4'h6: ch = 7'h36;  // '6'
         4'h7: ch = 7'h42;  // 'B'
         4'h8: ch = 7'h37;  // '7'
         4'h9: ch = 7'h38;  // '8'
         4'hA: ch = 7'h39;  // '9'
         4'hB: ch = 7'h43;  // 'C'
         4'hC: ch = 7'h2A;  // '*'
         4'hD: ch = 7'h30;  // '0'
         4'hE: ch = 7'h23;  // '#'
         4'hF: ch = 7'h44;  // 'D'
      endcase
      return ch;
   endfunction

endpackage

FILE: src/matrix_keypad_press_decoder_unit.sv
// top level of the 4x4 keypad press decoder with key buffer
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_func, req_row_levels, req_read_index
//   rsp     | out       | rsp_valid, rsp_stall, rsp_key_char .. rsp_entry_char
//
// one beat per cycle sustained while rsp_stall is low; a beat's response is valid once it has passed
// the input register with buffer read and then the result register
// reset clears the count, sets the last char to space and all row levels to released;
// buffer entries at or above the count read as zero, so the memory needs no clearing
// rsp_stall holds the result register and backs up into req_stall only when both stages are full
module matrix_keypad_press_decoder_unit
   import mkpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_row_levels,
   input  logic [4:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_key_char,
   output logic        rsp_key_seen,
   output logic        rsp_stored,
   output logic [6:0]  rsp_last_char,
   output logic [5:0]  rsp_key_count,
   output logic [6:0]  rsp_entry_char
);

   // input stage
   logic        s1_vld_ff, s1_vld_in;
   logic [1:0]  s1_func_ff;
   logic [15:0] s1_levels_ff;
   logic [4:0]  s1_index_ff;

   // block state
   logic [15:0]      prev_levels_ff, prev_levels_in;
   logic [CNT_W-1:0] count_ff, count_in;
   char_type         recent_ff, recent_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   char_type   key_ff, key_in;
   logic       seen_ff, seen_in;
   logic       stored_ff, stored_in;
   char_type   last_ff;
   logic [5:0] cnt_out_ff;
   char_type   entry_ff, entry_in;

   logic            accept, advance;
   scan_result_type scan;
   logic            wr_en;
   char_type        rd_data;

   assign advance   = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   mkpd_scan_decode u_decode (
      .prev_levels (prev_levels_ff),
      .cur_levels  (s1_levels_ff),
      .result      (scan)
   );

   assign wr_en = advance && (s1_func_ff == FUNC_SCAN) && scan.seen
                  && (count_ff < CNT_W'(BUFFER_SIZE));

   mkpd_key_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (scan.key),
      .rd_en   (accept),
      .rd_addr (req_read_index[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      prev_levels_in = prev_levels_ff;
      count_in       = count_ff;
      recent_in      = recent_ff;
      key_in         = '0;
      seen_in        = 1'b0;
      stored_in      = 1'b0;
      entry_in       = '0;
      unique case (s1_func_ff)
         FUNC_SCAN: begin
            prev_levels_in = s1_levels_ff;
            if (scan.seen) begin
               key_in    = scan.key;
               seen_in   = 1'b1;
               recent_in = scan.key;
               if (count_ff < CNT_W'(BUFFER_SIZE)) begin
                  count_in  = count_ff + CNT_W'(1);
                  stored_in = 1'b1;
               end
            end
         end
         FUNC_FLUSH: begin
            count_in  = '0;
            recent_in = SPACE_CHAR;
         end
         FUNC_READ: begin
            // entries past the fill count were not written since the last flush
            if ({1'b0, s1_index_ff} < count_ff) begin
               entry_in = rd_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (advance) begin
         s1_vld_in = 1'b0;
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prev_levels_ff <= '1;
         count_ff       <= '0;
         recent_ff      <= SPACE_CHAR;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            prev_levels_ff <= prev_levels_in;
            count_ff       <= count_in;
            recent_ff      <= recent_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff   <= req_func;
         s1_levels_ff <= req_row_levels;
         s1_index_ff  <= req_read_index;
      end
      if (advance) begin
         key_ff     <= key_in;
         seen_ff    <= seen_in;
         stored_ff  <= stored_in;
         last_ff    <= recent_in;
         cnt_out_ff <= 6'(count_in);
         entry_ff   <= entry_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_char   = key_ff;
   assign rsp_key_seen   = seen_ff;
   assign rsp_stored     = stored_ff;
   assign rsp_last_char  = last_ff;
   assign rsp_key_count  = cnt_out_ff;
   assign rsp_entry_char = entry_ff;

endmodule

FILE: src/mkpd_scan_decode.sv
// falling-edge detection per row and key lookup for one scan
module mkpd_scan_decode
   import mkpd_pkg::*;
(
   input  logic [15:0]     prev_levels,
   input  logic [15:0]     cur_levels,
   output scan_result_type result
);

   always_comb begin
      logic [3:0] fell;
      logic [1:0] col;
      logic       one_col;
      result = '0;
      for (int r = 0; r < 4; r++) begin
         fell    = prev_levels[4*r +: 4] & ~cur_levels[4*r +: 4];
         col     = 2'd0;
         one_col = 1'b1;
         unique case (fell)
            4'b0001: col = 2'd0;
            4'b0010: col = 2'd1;
            4'b0100: col = 2'd2;
            4'b1000: col = 2'd3;
            default: one_col = 1'b0;
         endcase
         // higher rows override lower ones
         if (one_col) begin
            result.seen = 1'b1;
            result.key  = key_lookup(2'(r), col);
         end
      end
   end

endmodule

FILE: src/mkpd_key_ram.sv
// key buffer memory, one write and one registered read port
module mkpd_key_ram
   import mkpd_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  char_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output char_type          rd_data
);

   char_type mem_ff [BUFFER_SIZE];
   char_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // write-first so a read issued alongside a write sees the new key
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/sv/tb_matrix_keypad_press_decoder_unit.sv
// self-checking testbench for the keypad press decoder: directed table, then random beats
module tb_matrix_keypad_press_decoder_unit;
   import mkpd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam int         PHASE_BEATS   = 300;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES  = 8;

   typedef struct packed {
      char_type   key_char;
      logic       key_seen;
      logic       stored;
      char_type   last_char;
      logic [5:0] key_count;
      char_type   entry_char;
   } key_report_type;

   typedef struct packed {
      logic [1:0]     func;
      logic [15:0]    levels;
      logic [4:0]     index;
      logic           typed;
      key_report_type report;
   } stim_row_type;

   localparam char_type KEY_MAP [4][4] = '{
      '{7'h31, 7'h32, 7'h33, 7'h41},
      '{7'h34, 7'h35, 7'h36, 7'h42},
      '{7'h37, 7'h38, 7'h39, 7'h43},
      '{7'h2A, 7'h30, 7'h23, 7'h44}
   };

   localparam int DIRECTED_ROWS = 24;

   // typed rows carry their expected result in the directed table itself; the rest use the predictor
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{FUNC_READ,   16'hFFFF, 5'd0,  1'b1, '{7'h00, 1'b0, 1'b0, SPACE_CHAR, 6'd0, 7'h00}},
      '{FUNC_UNUSED, 16'h0000, 5'd31, 1'b1, '{7'h00, 1'b0, 1'b0, SPACE_CHAR, 6'd0, 7'h00}},
      '{FUNC_SCAN,   16'hFFFF, 5'd0,  1'b1, '{7'h00, 1'b0, 1'b0, SPACE_CHAR, 6'd0, 7'h00}},
      '{FUNC_SCAN,   16'hFFFE, 5'd31, 1'b1, '{7'h31, 1'b1, 1'b1, 7'h31,      6'd1, 7'h00}},
      '{FUNC_SCAN,   16'hFFFE, 5'd0,  1'b1, '{7'h00, 1'b0, 1'b0, 7'h31,      6'd1, 7'h00}},
      '{FUNC_SCAN,   16'hFFF0, 5'd0,  1'b1, '{7'h00, 1'b0, 1'b0, 7'h31,      6'd1, 7'h00}},
      '{FUNC_SCAN,   16'hFFFF, 5'd0,  1'b0, '0},
      '{FUNC_SCAN,   16'h7FFF, 5'd0,  1'b1, '{7'h44, 1'b1, 1'b1, 7'h44,      6'd2, 7'h00}},
      '{FUNC_SCAN,   16'hFFF7, 5'd0,  1'b0, '0},
      '{FUNC_SCAN,   16'hFFFF, 5'd0,  1'b0, '0},
      '{FUNC_SCAN,   16'h7EDE, 5'd0,  1'b0, '0},
      '{FUNC_SCAN,   16'hFFFF, 5'd0,  1'b0, '0},
      '{FUNC_SCAN,   16'h0000, 5'd0,  1'b0, '0},
      '{FUNC_SCAN,   16'hFFFF, 5'd0,  1'b0, '0},
      '{FUNC_SCAN,   16'hDFFF, 5'd0,  1'b0, '0},
      '{FUNC_SCAN,   16'hBFFF, 5'd0,  1'b0, '0},
      '{FUNC_SCAN,   16'hEFFF, 5'd0,  1'b0, '0},
      '{FUNC_READ,   16'h0000, 5'd0,  1'b0, '0},
      '{FUNC_READ,   16'hFFFF, 5'd6,  1'b0, '0},
      '{FUNC_READ,   16'h0000, 5'd31, 1'b1, '{7'h00, 1'b0, 1'b0, 7'h2A,      6'd7, 7'h00}},
      '{FUNC_FLUSH,  16'h0000, 5'd31, 1'b1, '{7'h00, 1'b0, 1'b0, SPACE_CHAR, 6'd0, 7'h00}},
      '{FUNC_READ,   16'hFFFF, 5'd0,  1'b1, '{7'h00, 1'b0, 1'b0, SPACE_CHAR, 6'd0, 7'h00}},
      '{FUNC_SCAN,   16'hFFFF, 5'd0,  1'b0, '0},
      '{FUNC_UNUSED, 16'hFFFF, 5'd0,  1'b0, '0}
   };

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func       = FUNC_SCAN;
   logic [15:0] req_row_levels = 16'hFFFF;
   logic [4:0]  req_read_index = 5'd0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [6:0]  rsp_key_char;
   logic        rsp_key_seen;
   logic        rsp_stored;
   logic [6:0]  rsp_last_char;
   logic [5:0]  rsp_key_count;
   logic [6:0]  rsp_entry_char;

   // typed expectation that travels with the beat on the request lines
   logic           beat_typed  = 1'b0;
   key_report_type beat_golden = '0;

   int idle_pct  = 0;
   int stall_pct = 0;
   int fail_count  = 0;
   int idle_cycles = 0;

   key_report_type pending_reports [$];

   logic [3:0] held_levels [4];
   char_type   key_store [BUFFER_SIZE];
   int         stored_count;
   char_type   latest_char;

   matrix_keypad_press_decoder_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_row_levels (req_row_levels),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_char   (rsp_key_char),
      .rsp_key_seen   (rsp_key_seen),
      .rsp_stored     (rsp_stored),
      .rsp_last_char  (rsp_last_char),
      .rsp_key_count  (rsp_key_count),
      .rsp_entry_char (rsp_entry_char)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic key_report_type predict_report(input logic [1:0] func,
                                                     input logic [15:0] levels,
                                                     input logic [4:0] index);
      key_report_type rep;
      char_type       key;
      logic [3:0]     cur;
      logic [3:0]     fell;
      rep = '0;
      key = '0;
      case (func)
         FUNC_SCAN: begin
            for (int row = 0; row < 4; row++) begin
               cur  = levels[4*row +: 4];
               fell = held_levels[row] & ~cur;
               held_levels[row] = cur;
               // a row only counts when exactly one column fell
               if ($countones(fell) == 1) begin
                  for (int col = 0; col < 4; col++) begin
                     if (fell[col]) key = KEY_MAP[row][col];
                  end
               end
            end
            if (key != '0) begin
               rep.key_char = key;
               rep.key_seen = 1'b1;
               latest_char  = key;
               if (stored_count < BUFFER_SIZE) begin
                  key_store[stored_count] = key;
                  stored_count++;
                  rep.stored = 1'b1;
               end
            end
         end
         FUNC_FLUSH: begin
            foreach (key_store[i]) key_store[i] = '0;
            stored_count = 0;
            latest_char  = SPACE_CHAR;
         end
         FUNC_READ: begin
            if (index < BUFFER_SIZE) rep.entry_char = key_store[index];
         end
         default: ;
      endcase
      rep.last_char = latest_char;
      rep.key_count = stored_count[5:0];
      return rep;
   endfunction

   task automatic compare_field(input string name, input logic [6:0] want,
                                input logic [6:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      key_report_type want;
      logic           moved;
      if (reset) begin
         foreach (held_levels[i]) held_levels[i] = 4'hF;
         foreach (key_store[i]) key_store[i] = '0;
         stored_count = 0;
         latest_char  = SPACE_CHAR;
         idle_cycles  = 0;
      end else begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            want = predict_report(req_func, req_row_levels, req_read_index);
            if (beat_typed) want = beat_golden;
            pending_reports.push_back(want);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_reports.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, key_char %0d",
                        $time, rsp_key_char);
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               compare_field("key_char", want.key_char, rsp_key_char);
               compare_field("key_seen", 7'(want.key_seen), 7'(rsp_key_seen));
               compare_field("stored", 7'(want.stored), 7'(rsp_stored));
               compare_field("last_char", want.last_char, rsp_last_char);
               compare_field("key_count", 7'(want.key_count), 7'(rsp_key_count));
               compare_field("entry_char", want.entry_char, rsp_entry_char);
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   task automatic send_beat(input stim_row_type row);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= row.func;
      req_row_levels <= row.levels;
      req_read_index <= row.index;
      beat_typed     <= row.typed;
      beat_golden    <= row.report;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("matrix_keypad_press_decoder_unit verification failed");
      $finish;
   end

   initial begin : stimulus
      localparam int IDLE_OF  [4] = '{0, 56, 0, 11};
      localparam int STALL_OF [4] = '{0, 0, 56, 11};
      stim_row_type row;
      logic         key_held;
      int           pick;
      int           r1;
      int           r2;
      key_held = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) send_beat(DIRECTED[i]);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = IDLE_OF[phase];
         stall_pct = STALL_OF[phase];
         for (int n = 0; n < PHASE_BEATS; n++) begin
            row        = '0;
            row.levels = 16'($urandom);
            row.index  = 5'($urandom);
            pick       = $urandom_range(99);
            if (pick < 8) begin
               row.func = FUNC_READ;
            end else if (pick < 9) begin
               row.func = FUNC_FLUSH;
            end else if (pick < 11) begin
               row.func = FUNC_UNUSED;
            end else if (pick < 21) begin
               row.func = FUNC_SCAN;
            end else begin
               // press and release pairs so keys keep landing in the buffer
               row.func = FUNC_SCAN;
               if (key_held) begin
                  row.levels = 16'hFFFF;
                  key_held   = 1'b0;
               end else begin
                  r1         = $urandom_range(3);
                  row.levels = 16'hFFFF;
                  row.levels[4*r1 + $urandom_range(3)] = 1'b0;
                  if ($urandom_range(7) == 0) begin
                     r2 = (r1 + 1 + $urandom_range(2)) % 4;
                     row.levels[4*r2 + $urandom_range(3)] = 1'b0;
                  end
                  key_held = 1'b1;
               end
            end
            send_beat(row);
         end
         drain_results();
      end

      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("matrix_keypad_press_decoder_unit verification clean");
      end else begin
         $display("matrix_keypad_press_decoder_unit verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/mkpd_pkg.sv
src/mkpd_scan_decode.sv
src/mkpd_key_ram.sv
src/matrix_keypad_press_decoder_unit.sv
tb/sv/tb_matrix_keypad_press_decoder_unit.sv
